>>> rtl/dcb_pkg.sv
// Package for the multilevel DC-balance compensator.
// Holds sizes, codes, channel payload types and the saturating sum helper.
// No dependencies.
package dcb_pkg;

  localparam int SUM_WIDTH  = 16;
  localparam int RUN_SUM_W  = 16;
  localparam int ACTION_W   = 2;
  localparam int SYMBOL_W   = 4;
  localparam int WEIGHT_W   = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_MOD_LEVEL   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOL_MASK = 1'd1;

  localparam logic [1:0]          MOD_LEVEL_RST   = 2'd0;
  localparam logic [SYMBOL_W-1:0] SYMBOL_MASK_RST = 4'd1;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_DATA   = 2'd0,
    ACT_INJECT = 2'd1,
    ACT_CHECK  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MODE_2  = 2'd0,
    MODE_4  = 2'd1,
    MODE_8  = 2'd2,
    MODE_16 = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]          mod_level;
    logic [SYMBOL_W-1:0] symbol_mask;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SYMBOL_W-1:0] symbol;
  } item_t;

  typedef struct packed {
    logic                        symbol_valid;
    logic [SYMBOL_W-1:0]         symbol_index;
    logic                        balanced;
    logic signed [RUN_SUM_W-1:0] running_sum;
  } result_t;

  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] s,
    input logic signed [WEIGHT_W-1:0]  w
  );
    logic signed [SUM_WIDTH:0] t;
    t = {s[SUM_WIDTH-1], s} + {{(SUM_WIDTH+1-WEIGHT_W){w[WEIGHT_W-1]}}, w};
    if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
      return t[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end
    return t[SUM_WIDTH-1:0];
  endfunction

endpackage

>>> rtl/dcb_in_if.sv
// Input channel of the DC-balance compensator: valid/ready plus one item.
// Depends on dcb_pkg.
interface dcb_in_if
  import dcb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SYMBOL_W-1:0] symbol;

  modport source (output valid, action, symbol, input ready);
  modport sink   (input valid, action, symbol, output ready);
endinterface

>>> rtl/dcb_out_if.sv
// Result channel of the DC-balance compensator: valid/ready plus one result.
// Depends on dcb_pkg.
interface dcb_out_if
  import dcb_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic                        symbol_valid;
  logic [SYMBOL_W-1:0]         symbol_index;
  logic                        balanced;
  logic signed [RUN_SUM_W-1:0] running_sum;

  modport source (output valid, symbol_valid, symbol_index, balanced, running_sum,
                  input ready);
  modport sink   (input valid, symbol_valid, symbol_index, balanced, running_sum,
                  output ready);
endinterface

>>> rtl/dcb_regs.sv
// APB-style configuration registers: mode and data symbol mask.
// Depends on dcb_pkg.
module dcb_regs
  import dcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [1:0]           mod_level_r;
  logic [SYMBOL_W-1:0]  symbol_mask_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_level_r   <= MOD_LEVEL_RST;
      symbol_mask_r <= SYMBOL_MASK_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MOD_LEVEL:   mod_level_r   <= pwdata[1:0];
        REG_SYMBOL_MASK: symbol_mask_r <= pwdata[SYMBOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MOD_LEVEL:   prdata = {{(CFG_DATA_W-2){1'b0}}, mod_level_r};
      REG_SYMBOL_MASK: prdata = {{(CFG_DATA_W-SYMBOL_W){1'b0}}, symbol_mask_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg = {mod_level_r, symbol_mask_r};

endmodule

>>> rtl/dcb_core.sv
// Disparity datapath: running sum register, level selection and saturating update.
// Depends on dcb_pkg.
module dcb_core
  import dcb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic signed [SUM_WIDTH-1:0]           sum_r;
  logic signed [SUM_WIDTH-1:0]           sum_nxt;
  logic [SYMBOL_W:0]                     n_lv;
  logic [SYMBOL_W-1:0]                   nm1;
  logic [SYMBOL_W-1:0]                   data_idx;
  logic signed [WEIGHT_W-1:0]            w_data;
  logic signed [WEIGHT_W-1:0]            w_inj;
  logic [WEIGHT_W-1:0]                   inj_twice;
  logic [SYMBOL_W-1:0]                   inj_idx;
  logic                                  neg;

  assign n_lv     = (SYMBOL_W+1)'(2) << cfg.mod_level;
  assign nm1      = SYMBOL_W'(n_lv - (SYMBOL_W+1)'(1));
  assign data_idx = item.symbol & cfg.symbol_mask & nm1;
  assign w_data   = $signed({1'b0, data_idx, 1'b0}) - $signed({2'b00, nm1});
  assign neg      = sum_r[SUM_WIDTH-1];

  always_comb begin
    case (mode_t'(cfg.mod_level))
      MODE_2: begin
        w_inj = neg ? 6'sd1 : -6'sd1;
      end
      MODE_4: begin
        if (neg) begin
          w_inj = (sum_r < -1) ? 6'sd3 : 6'sd1;
        end else begin
          w_inj = (sum_r > 1) ? -6'sd3 : -6'sd1;
        end
      end
      MODE_8: begin
        if (neg) begin
          if (sum_r < -5)      w_inj = 6'sd7;
          else if (sum_r < -3) w_inj = 6'sd5;
          else if (sum_r < -1) w_inj = 6'sd3;
          else                 w_inj = 6'sd1;
        end else begin
          if (sum_r > 5)       w_inj = -6'sd7;
          else if (sum_r > 3)  w_inj = -6'sd5;
          else if (sum_r > 1)  w_inj = -6'sd3;
          else                 w_inj = -6'sd1;
        end
      end
      default: begin
        w_inj = '0;
      end
    endcase
  end

  assign inj_twice = {2'b00, nm1} + w_inj;
  assign inj_idx   = inj_twice[SYMBOL_W:1];

  always_comb begin
    sum_nxt          = sum_r;
    res.symbol_valid = 1'b0;
    res.symbol_index = '0;
    res.balanced     = 1'b0;
    case (action_t'(item.action))
      ACT_DATA: begin
        res.symbol_valid = 1'b1;
        res.symbol_index = data_idx;
        sum_nxt          = sat_add(sum_r, w_data);
      end
      ACT_INJECT: begin
        if (mode_t'(cfg.mod_level) != MODE_16) begin
          res.symbol_valid = 1'b1;
          res.symbol_index = inj_idx;
          sum_nxt          = sat_add(sum_r, w_inj);
        end
        res.balanced = (sum_nxt == '0);
      end
      ACT_CHECK: begin
        res.balanced = (sum_r == '0);
      end
      default: ;
    endcase
    res.running_sum = RUN_SUM_W'(sum_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (en) begin
      sum_r <= sum_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sum_r))
    else $error("Disparity sum changed without a transaction.");

  a_idx_in_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.symbol_valid) |-> ((res.symbol_index & ~nm1) == '0))
    else $error("Emitted level index outside the current mode.");

  a_balanced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.balanced) |=> (sum_r == '0))
    else $error("Balanced reported while the sum is not zero.");
`endif

endmodule

>>> rtl/multilevel_dc_balance_compensator_unit.sv
// Top level of the multilevel DC-balance compensator.
// Depends on dcb_pkg, dcb_in_if, dcb_out_if, dcb_regs and dcb_core.
//
// The unit accepts one transaction per clock cycle while the result side is
// ready, and returns exactly one result per transaction through the input
// register and then the result register. The rate is set by the disparity sum
// register, whose add, saturate and threshold compare are combinational. The
// user must write configuration through the APB port only while no transaction
// is in flight, which the block does not enforce; no clearing pass after reset.
module multilevel_dc_balance_compensator_unit
  import dcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dcb_in_if.sink                in_ch,
  dcb_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  result_t res;
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    advance;

  dcb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcb_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.action <= in_ch.action;
      s1_item_r.symbol <= in_ch.symbol;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.symbol_valid = out_res_r.symbol_valid;
  assign out_ch.symbol_index = out_res_r.symbol_index;
  assign out_ch.balanced     = out_res_r.balanced;
  assign out_ch.running_sum  = out_res_r.running_sum;

`ifndef NO_ASSERTIONS
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("Result appeared without a transaction in the input register.");
`endif

endmodule
